// ===== rtl/edf_pkg.sv =====
// types and constants shared by the edf equal length task scheduler
`timescale 1ns / 1ps

package edf_pkg;

    localparam int unsigned FIELD_W  = 16;
    localparam int unsigned DUR_W    = 12;
    localparam int unsigned IDX_W    = 6;
    localparam int unsigned START_W  = 19;
    localparam int unsigned STATUS_W = 2;

    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_MISS     = 2'd1;
    localparam logic [STATUS_W-1:0] ST_OVERFLOW = 2'd2;

    typedef struct packed {
        logic [FIELD_W-1:0] rel_time;
        logic [FIELD_W-1:0] deadline;
        logic               last_task;
    } t_task_in;

    typedef struct packed {
        logic [IDX_W-1:0]    task_index;
        logic [START_W-1:0]  start_time;
        logic [STATUS_W-1:0] status;
        logic                last_result;
    } t_task_res;

endpackage

// ===== rtl/edf_equal_length_task_scheduler.sv =====
// edf equal length task scheduler: task loading, edf sequencer and result emission
`timescale 1ns / 1ps

// Tasks (release time, deadline) are loaded one beat each while o_in_stall is low and
// are stored in on-chip arrays. The beat marked last_task starts greedy non-preemptive
// earliest-deadline-first scheduling, during which o_in_stall stays high. Every time
// and deadline comparison is made by one shared comparator under a small sequencer:
// a released task is admitted through S_ADM_RD and S_ADM_CHK, each decision closes its
// admission check, the minimum-deadline scan walks all stored tasks through the deadline
// array read port, and the start check in S_DECIDE follows; an idle gap is jumped over
// to the next release. The results are then emitted, one beat per task in load order,
// and the output may stall them. A deadline miss or an overflowed set gives a single
// result beat instead. task_duration is written through the configuration channel,
// which is ready only while the block is idle.
module edf_equal_length_task_scheduler #(
    parameter int unsigned MAX_TASKS = 64,
    parameter int unsigned TIME_BITS = 16
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    input  edf_pkg::t_task_in          i_in_data,
    output logic                       o_in_stall,
    output logic                       o_out_valid,
    output edf_pkg::t_task_res         o_out_data,
    input  logic                       i_out_stall,
    input  logic                       i_cfg_valid,
    input  logic [edf_pkg::DUR_W-1:0]  i_cfg_data,
    output logic                       o_cfg_ready
);
    import edf_pkg::*;

    localparam int unsigned AW   = (MAX_TASKS > 2) ? $clog2(MAX_TASKS) : 1;
    localparam int unsigned CW   = $clog2(MAX_TASKS + 1);
    localparam int unsigned DW   = (TIME_BITS < FIELD_W) ? TIME_BITS : FIELD_W;
    localparam int unsigned TW   = ((TIME_BITS > 18) ? TIME_BITS : 18) + 1;
    localparam int unsigned CMPW = TW + 1;

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_ADM_RD  = 3'd1;
    localparam logic [2:0] S_ADM_CHK = 3'd2;
    localparam logic [2:0] S_SCAN    = 3'd3;
    localparam logic [2:0] S_DECIDE  = 3'd4;
    localparam logic [2:0] S_EMIT_RD = 3'd5;
    localparam logic [2:0] S_EMIT_LD = 3'd6;
    localparam logic [2:0] S_RESULT  = 3'd7;

    // task arrays
    logic [DW-1:0]      release_mem  [MAX_TASKS];
    logic [DW-1:0]      deadline_mem [MAX_TASKS];
    logic [START_W-1:0] start_mem    [MAX_TASKS];
    logic [DW-1:0]      r_rel_q;
    logic [DW-1:0]      r_dl_q;
    logic [START_W-1:0] r_start_q;

    // control state
    logic [2:0]           r_state, n_state;
    logic [CW-1:0]        r_count, n_count;
    logic                 r_ovf, n_ovf;
    logic [MAX_TASKS-1:0] r_done, n_done;
    logic [MAX_TASKS-1:0] r_ready, n_ready;
    logic [TW-1:0]        r_time, n_time;
    logic [CW-1:0]        r_ptr, n_ptr;
    logic [CW-1:0]        r_j, n_j;
    logic [CW-1:0]        r_k, n_k;
    logic                 r_found, n_found;
    logic                 r_out_valid, n_out_valid;
    logic [DUR_W-1:0]     r_dur;

    // payload
    logic [DW-1:0]       r_best, n_best;
    logic [AW-1:0]       r_sel, n_sel;
    logic [IDX_W-1:0]    r_res_idx, n_res_idx;
    logic [START_W-1:0]  r_res_start, n_res_start;
    logic [STATUS_W-1:0] r_res_status, n_res_status;
    t_task_res           r_out, n_out;

    logic          in_acc;
    logic          out_free;
    logic          load_we;
    logic          start_we;
    logic [CW-1:0] j_prev;
    logic [CMPW-1:0] cmp_a, cmp_b;
    logic          cmp_lt;

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_cfg_ready = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    assign in_acc   = i_in_valid && !o_in_stall;
    assign out_free = !r_out_valid || !i_out_stall;
    assign load_we  = in_acc && (r_count < CW'(MAX_TASKS));
    assign start_we = (r_state == S_DECIDE) && r_found && !cmp_lt;
    assign j_prev   = r_j - CW'(1);

    // shared less-than unit
    always_comb begin
        unique case (r_state)
            S_SCAN: begin
                cmp_a = CMPW'(r_dl_q);
                cmp_b = CMPW'(r_best);
            end
            S_DECIDE: begin
                cmp_a = CMPW'(r_best);
                cmp_b = CMPW'(r_time) + CMPW'(r_dur);
            end
            default: begin
                cmp_a = CMPW'(r_time);
                cmp_b = CMPW'(r_rel_q);
            end
        endcase
    end
    assign cmp_lt = (cmp_a < cmp_b);

    always_ff @(posedge i_clk) begin
        if (load_we) begin
            release_mem[r_count[AW-1:0]]  <= DW'(i_in_data.rel_time);
            deadline_mem[r_count[AW-1:0]] <= DW'(i_in_data.deadline);
        end
        r_rel_q <= release_mem[r_ptr[AW-1:0]];
        r_dl_q  <= deadline_mem[r_j[AW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (start_we) begin
            start_mem[r_sel] <= r_time[START_W-1:0];
        end
        r_start_q <= start_mem[r_j[AW-1:0]];
    end

    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_ovf        = r_ovf;
        n_done       = r_done;
        n_ready      = r_ready;
        n_time       = r_time;
        n_ptr        = r_ptr;
        n_j          = r_j;
        n_k          = r_k;
        n_found      = r_found;
        n_out_valid  = r_out_valid;
        n_best       = r_best;
        n_sel        = r_sel;
        n_res_idx    = r_res_idx;
        n_res_start  = r_res_start;
        n_res_status = r_res_status;
        n_out        = r_out;

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    if (load_we) begin
                        n_count = r_count + CW'(1);
                    end else begin
                        n_ovf = 1'b1;
                    end
                    if (i_in_data.last_task) begin
                        if (r_ovf || !load_we) begin
                            n_res_idx    = '0;
                            n_res_start  = '0;
                            n_res_status = ST_OVERFLOW;
                            n_state      = S_RESULT;
                        end else begin
                            n_k     = '0;
                            n_state = S_ADM_RD;
                        end
                    end
                end
            end
            S_ADM_RD: begin
                n_state = S_ADM_CHK;
            end
            S_ADM_CHK: begin
                priority if (r_ptr < r_count && !cmp_lt) begin
                    n_ready[r_ptr[AW-1:0]] = 1'b1;
                    n_ptr   = r_ptr + CW'(1);
                    n_state = S_ADM_RD;
                end else if (r_ready == '0 && r_ptr < r_count) begin
                    // idle gap: jump to next release
                    n_time = TW'(r_rel_q);
                end else begin
                    n_j     = '0;
                    n_found = 1'b0;
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (r_j != '0) begin
                    if (r_ready[j_prev[AW-1:0]] && (!r_found || cmp_lt)) begin
                        n_best  = r_dl_q;
                        n_sel   = j_prev[AW-1:0];
                        n_found = 1'b1;
                    end
                end
                if (r_j == r_count) begin
                    n_state = S_DECIDE;
                end else begin
                    n_j = r_j + CW'(1);
                end
            end
            S_DECIDE: begin
                priority if (!r_found) begin
                    n_j     = '0;
                    n_state = S_EMIT_RD;
                end else if (cmp_lt) begin
                    n_res_idx    = IDX_W'(r_sel);
                    n_res_start  = r_time[START_W-1:0];
                    n_res_status = ST_MISS;
                    n_state      = S_RESULT;
                end else begin
                    n_done[r_sel]  = 1'b1;
                    n_ready[r_sel] = 1'b0;
                    n_time         = r_time + TW'(r_dur);
                    n_k            = r_k + CW'(1);
                    if (r_k + CW'(1) == r_count) begin
                        n_j     = '0;
                        n_state = S_EMIT_RD;
                    end else begin
                        n_state = S_ADM_RD;
                    end
                end
            end
            S_EMIT_RD: begin
                n_state = S_EMIT_LD;
            end
            S_EMIT_LD: begin
                if (out_free) begin
                    n_out_valid       = 1'b1;
                    n_out.task_index  = IDX_W'(r_j);
                    n_out.start_time  = r_start_q;
                    n_out.status      = ST_OK;
                    n_out.last_result = (r_j + CW'(1) == r_count);
                    if (r_j + CW'(1) == r_count) begin
                        n_count = '0;
                        n_ovf   = 1'b0;
                        n_done  = '0;
                        n_ready = '0;
                        n_time  = '0;
                        n_ptr   = '0;
                        n_state = S_IDLE;
                    end else begin
                        n_j     = r_j + CW'(1);
                        n_state = S_EMIT_RD;
                    end
                end
            end
            S_RESULT: begin
                if (out_free) begin
                    n_out_valid       = 1'b1;
                    n_out.task_index  = r_res_idx;
                    n_out.start_time  = r_res_start;
                    n_out.status      = r_res_status;
                    n_out.last_result = 1'b1;
                    n_count = '0;
                    n_ovf   = 1'b0;
                    n_done  = '0;
                    n_ready = '0;
                    n_time  = '0;
                    n_ptr   = '0;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_ovf       <= 1'b0;
            r_done      <= '0;
            r_ready     <= '0;
            r_time      <= '0;
            r_ptr       <= '0;
            r_j         <= '0;
            r_k         <= '0;
            r_found     <= 1'b0;
            r_out_valid <= 1'b0;
            r_dur       <= DUR_W'(1);
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_ovf       <= n_ovf;
            r_done      <= n_done;
            r_ready     <= n_ready;
            r_time      <= n_time;
            r_ptr       <= n_ptr;
            r_j         <= n_j;
            r_k         <= n_k;
            r_found     <= n_found;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                r_dur <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_best       <= n_best;
        r_sel        <= n_sel;
        r_res_idx    <= n_res_idx;
        r_res_start  <= n_res_start;
        r_res_status <= n_res_status;
        r_out        <= n_out;
    end

    // a task is never both waiting and finished
    a_ready_done_disjoint: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ready & r_done) == '0)
        else $error("task both ready and done");

    // admission never runs past the stored set
    a_ptr_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ptr <= r_count)
        else $error("release pointer beyond task count");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_TASKS))
        else $error("task count beyond capacity");

    // the scan always finds a waiting task
    a_scan_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_DECIDE |-> r_found)
        else $error("decision without a selected task");

    // time advances by the task duration after every start
    a_time_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start_we |=> r_time == $past(r_time) + TW'($past(r_dur)))
        else $error("time did not advance by task duration");

endmodule

// ===== sim/tb_edf_equal_length_task_scheduler.sv =====
// self-checking testbench for the edf equal length task scheduler
`timescale 1ns / 1ps

module tb_edf_equal_length_task_scheduler;
    import edf_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int LONG_HOLD      = 400;
    localparam int N_ROWS         = 20;

    typedef struct packed {
        t_task_in  item;
        logic      typed;
        t_task_res res;
    } t_row;

    // directed beats, typed results only where obvious
    localparam t_row DIR_ROWS [N_ROWS] = '{
        '{'{16'd0,     16'd1,     1'b1}, 1'b1, '{6'd0, 19'd0,     ST_OK,   1'b1}},
        '{'{16'd0,     16'd0,     1'b1}, 1'b1, '{6'd0, 19'd0,     ST_MISS, 1'b1}},
        '{'{16'hFFFF,  16'hFFFF,  1'b1}, 1'b1, '{6'd0, 19'd65535, ST_MISS, 1'b1}},
        '{'{16'd0,     16'hFFFF,  1'b1}, 1'b1, '{6'd0, 19'd0,     ST_OK,   1'b1}},
        '{'{16'hFFFF,  16'd0,     1'b1}, 1'b1, '{6'd0, 19'd65535, ST_MISS, 1'b1}},
        '{'{16'd0,     16'd10,    1'b0}, 1'b0, '0},
        '{'{16'd0,     16'd5,     1'b0}, 1'b0, '0},
        '{'{16'd0,     16'd7,     1'b1}, 1'b0, '0},
        '{'{16'd0,     16'd9,     1'b0}, 1'b0, '0},
        '{'{16'd0,     16'd9,     1'b0}, 1'b0, '0},
        '{'{16'd1,     16'd9,     1'b1}, 1'b0, '0},
        '{'{16'd5,     16'd100,   1'b0}, 1'b0, '0},
        '{'{16'd50,    16'd100,   1'b1}, 1'b0, '0},
        '{'{16'd10,    16'd100,   1'b0}, 1'b0, '0},
        '{'{16'd2,     16'd3,     1'b1}, 1'b0, '0},
        '{'{16'd0,     16'd1,     1'b0}, 1'b0, '0},
        '{'{16'd0,     16'd1,     1'b1}, 1'b0, '0},
        '{'{16'd3,     16'd40000, 1'b0}, 1'b0, '0},
        '{'{16'd3,     16'd40000, 1'b0}, 1'b0, '0},
        '{'{16'd32768, 16'hFFFF,  1'b1}, 1'b0, '0}
    };

    logic               i_clk;
    logic               i_rst_n;
    logic               i_in_valid;
    t_task_in           i_in_data;
    logic               o_in_stall;
    logic               o_out_valid;
    t_task_res          o_out_data;
    logic               i_out_stall;
    logic               i_cfg_valid;
    logic [DUR_W-1:0]   i_cfg_data;
    logic               o_cfg_ready;

    logic               typed_now;
    t_task_res          typed_res_now;

    // scheduler state mirror
    logic [FIELD_W-1:0] rel_mem [64];
    logic [FIELD_W-1:0] dl_mem [64];
    int unsigned        set_size = 0;
    bit                 set_overflow = 1'b0;
    logic [DUR_W-1:0]   task_len = DUR_W'(1);
    t_task_res          sched_out [$];
    t_task_res          expected_res [$];

    int                 mismatch_count = 0;
    int                 quiet_cycles = 0;
    int                 hold_requests = 0;
    int                 hold_served = 0;

    edf_equal_length_task_scheduler u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_data   (i_in_data),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_out_stall (i_out_stall),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .o_cfg_ready (o_cfg_ready)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // loads one task and, on the last one, schedules the set into sched_out
    function automatic void schedule_tasks(input t_task_in it);
        int unsigned        now;
        int unsigned        ptr;
        int unsigned        sel;
        int unsigned        n;
        logic [63:0]        ready;
        logic [63:0]        done;
        logic [START_W-1:0] starts [64];
        sched_out.delete();
        if (set_size < 64) begin
            rel_mem[set_size] = it.rel_time;
            dl_mem[set_size]  = it.deadline;
            set_size++;
        end else begin
            set_overflow = 1'b1;
        end
        if (!it.last_task) return;
        n = set_size;
        set_size = 0;
        if (set_overflow) begin
            set_overflow = 1'b0;
            sched_out.push_back(t_task_res'{6'd0, 19'd0, ST_OVERFLOW, 1'b1});
            return;
        end
        now = 0;
        ptr = 0;
        ready = '0;
        done = '0;
        for (int k = 0; k < n; k++) begin
            // admit released tasks, jump ahead when nothing is waiting
            for (int pass = 0; pass < 2; pass++) begin
                if (pass == 1) begin
                    if (ready != '0 || ptr >= n) break;
                    now = rel_mem[ptr];
                end
                while (ptr < n && rel_mem[ptr] <= now) begin
                    if (!done[ptr]) ready[ptr] = 1'b1;
                    ptr++;
                end
            end
            sel = 64;
            for (int j = 0; j < n; j++) begin
                if (ready[j] && (sel == 64 || dl_mem[j] < dl_mem[sel])) sel = j;
            end
            if (sel == 64) break;
            if (dl_mem[sel] < now + task_len) begin
                sched_out.push_back(t_task_res'{6'(sel), 19'(now), ST_MISS, 1'b1});
                return;
            end
            starts[sel] = 19'(now);
            done[sel]   = 1'b1;
            ready[sel]  = 1'b0;
            now += task_len;
        end
        for (int k = 0; k < n; k++) begin
            sched_out.push_back(t_task_res'{6'(k), starts[k], ST_OK, k == n - 1});
        end
    endfunction

    always @(posedge i_clk) begin
        bit        busy;
        t_task_res want;
        busy = 1'b0;
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) begin
                task_len = i_cfg_data;
                busy = 1'b1;
            end
            if (i_in_valid && !o_in_stall) begin
                busy = 1'b1;
                schedule_tasks(i_in_data);
                if (typed_now) begin
                    expected_res.push_back(typed_res_now);
                end else begin
                    foreach (sched_out[k]) expected_res.push_back(sched_out[k]);
                end
            end
            if (o_out_valid && !i_out_stall) begin
                busy = 1'b1;
                if (expected_res.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("unexpected beat: idx %0d start %0d status %0d last %0d",
                                 o_out_data.task_index, o_out_data.start_time,
                                 o_out_data.status, o_out_data.last_result);
                end else begin
                    want = expected_res.pop_front();
                    if (want.task_index !== o_out_data.task_index ||
                        want.start_time !== o_out_data.start_time ||
                        want.status !== o_out_data.status ||
                        want.last_result !== o_out_data.last_result) begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display({"mismatch: exp idx %0d start %0d status %0d last %0d,",
                                      " got idx %0d start %0d status %0d last %0d"},
                                     want.task_index, want.start_time, want.status,
                                     want.last_result, o_out_data.task_index,
                                     o_out_data.start_time, o_out_data.status,
                                     o_out_data.last_result);
                    end
                end
            end
            quiet_cycles = busy ? 0 : quiet_cycles + 1;
        end
    end

    initial begin
        wait (quiet_cycles >= WATCHDOG_LIMIT);
        $display("[FAIL] regression broken");
        $finish;
    end

    // result side stall pattern
    initial begin
        int r;
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_requests != hold_served) begin
                hold_served++;
                i_out_stall <= 1'b1;
                repeat (LONG_HOLD - 1) @(negedge i_clk);
            end else begin
                r = $urandom_range(0, 9);
                if (r < 3) begin
                    i_out_stall <= 1'b0;
                    repeat ($urandom_range(10, 50) - 1) @(negedge i_clk);
                end else if (r < 9) begin
                    i_out_stall <= ($urandom_range(0, 2) == 0);
                end else begin
                    i_out_stall <= 1'b1;
                    repeat ($urandom_range(15, 60) - 1) @(negedge i_clk);
                end
            end
        end
    end

    task automatic send_task(input t_task_in it, input logic typed, input t_task_res tr,
                             input bit burst);
        int gap;
        int r;
        r = $urandom_range(0, 19);
        gap = burst ? 0 : (r < 12 ? 0 : (r < 18 ? $urandom_range(1, 3)
                                                : $urandom_range(8, 40)));
        if (gap > 0) begin
            if (i_in_valid) i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_in_data     <= it;
        typed_now     <= typed;
        typed_res_now <= tr;
        do @(posedge i_clk); while (o_in_stall);
        @(negedge i_clk);
    endtask

    task automatic pause_until_drained();
        if (i_in_valid) i_in_valid <= 1'b0;
        @(negedge i_clk);
        while (expected_res.size() != 0) @(negedge i_clk);
    endtask

    task automatic write_duration(input logic [DUR_W-1:0] value);
        pause_until_drained();
        repeat (16) @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // one task set; mostly sorted releases with reachable deadlines
    task automatic send_random_set(input int n);
        int       mode;
        int       rel;
        int       dl;
        int       dur;
        bit       burst;
        t_task_in it;
        mode  = $urandom_range(0, 9);
        burst = ($urandom_range(0, 3) == 0);
        dur   = task_len;
        rel   = $urandom_range(0, 1) ? $urandom_range(0, 300) : $urandom_range(0, 65535);
        for (int i = 0; i < n; i++) begin
            if (mode <= 6) begin
                rel += $urandom_range(0, dur + 3);
                if (rel > 65535) rel = 65535;
                dl = rel + dur * $urandom_range(1, n + 1) + $urandom_range(0, 20);
            end else if (mode == 7) begin
                rel = $urandom_range(0, 65535);
                dl  = $urandom_range(0, 65535);
            end else if (mode == 8) begin
                rel += $urandom_range(0, 5);
                if (rel > 65535) rel = 65535;
                dl = rel + $urandom_range(0, dur);
            end else begin
                rel = 0;
                dl  = $urandom_range(0, 65535);
            end
            if (dl > 65535) dl = 65535;
            it = '{16'(rel), 16'(dl), i == n - 1};
            send_task(it, 1'b0, '0, burst);
        end
    endtask

    initial begin
        int               phase_items;
        int               n;
        logic [DUR_W-1:0] durations [5];
        i_rst_n       = 1'b0;
        i_in_valid    = 1'b0;
        i_in_data     = '0;
        i_cfg_valid   = 1'b0;
        i_cfg_data    = '0;
        typed_now     = 1'b0;
        typed_res_now = '0;
        durations = '{12'd0, 12'd4095, 12'($urandom_range(2, 4094)), 12'd3, 12'd1};
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (int r = 0; r < N_ROWS; r++) begin
            send_task(DIR_ROWS[r].item, DIR_ROWS[r].typed, DIR_ROWS[r].res, 1'b0);
        end

        for (int p = 0; p < 5; p++) begin
            write_duration(durations[p]);
            // output held off while tasks keep coming
            if (p == 2) hold_requests++;
            // one task beyond a full set
            if (p == 3) begin
                send_random_set(65);
            end
            phase_items = 0;
            while (phase_items < 10) begin
                n = ($urandom_range(0, 7) == 0) ? $urandom_range(7, 20) : $urandom_range(1, 6);
                send_random_set(n);
                phase_items += n;
                if ($urandom_range(0, 3) == 0) pause_until_drained();
            end
        end

        pause_until_drained();
        repeat (64) @(negedge i_clk);
        if (mismatch_count == 0 && expected_res.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
